// File: design/dsf_pkg.sv
package dsf_pkg;

  // Table geometry
  localparam int TableEntries = 64;
  localparam int AddrW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW = AddrW + 1;

  // Request and result field widths
  localparam int IdW = 32;
  localparam int SeqW = 8;
  localparam int EntryW = IdW + SeqW;

  // Result codes
  typedef enum logic [1:0] {
    OUT_PUBLIC    = 2'd0,
    OUT_NEW_SEQ   = 2'd1,
    OUT_DUPLICATE = 2'd2,
    OUT_INSERTED  = 2'd3
  } outcome_t;

  // Finished result handed from the scan engine to the output stage
  typedef struct packed {
    logic     valid;
    logic     forward;
    outcome_t outcome;
  } result_t;

endpackage

// File: design/dsf_req_if.sv
interface dsf_req_if
  import dsf_pkg::*;
  ;
  logic            valid;
  logic            ready;
  logic [IdW-1:0]  sender_id;
  logic [SeqW-1:0] sequence_req;

  modport source(output valid, output sender_id, output sequence_req, input ready);
  modport sink(input valid, input sender_id, input sequence_req, output ready);
endinterface

// File: design/dsf_rsp_if.sv
interface dsf_rsp_if;
  logic       valid;
  logic       ready;
  logic       forward;
  logic [1:0] outcome;

  modport source(output valid, output forward, output outcome, input ready);
  modport sink(input valid, input forward, input outcome, output ready);
endinterface

// File: design/duplicate_sequence_filter_top.sv
// Duplicate sequence filter.
// req_ch carries one received frame per request: sender_id and sequence_req.
// rsp_ch returns one result per request: forward (1 pass, 0 drop) and
// outcome (public, new sequence, duplicate, newly inserted).
// A zero sender_id passes without touching the table; its result is ready
// in the cycle after acceptance. Any other ID is looked up by reading the
// sender table one entry per cycle from a single-port-read RAM, lowest slot
// first, stopping at the first match. A match ends the scan there; with
// no match the whole table is read and the entry is inserted at the
// insert pointer. One request is in flight at a time; the next is taken
// in the cycle after the result has moved to the output register.
// Reset clears all entry valid bits, the insert pointer and the control
// state; no clearing pass is needed, so requests are taken right away.
// When the receiver stalls, the result holds in the output register and a
// second finished result waits in the scan engine, which then stops taking
// requests.
module duplicate_sequence_filter_top
  import dsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  dsf_req_if.sink   req_ch,
  dsf_rsp_if.source rsp_ch
);

  result_t res;
  logic    res_ready;

  dsf_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .req_ch   (req_ch),
    .res_ready(res_ready),
    .res      (res)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = !rsp_ch.valid || rsp_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_ch.valid <= 1'b0;
    end else if (res_ready) begin
      rsp_ch.valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      rsp_ch.forward <= res.forward;
      rsp_ch.outcome <= res.outcome;
    end
  end

endmodule

// File: design/dsf_ram.sv
module dsf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  // Write one entry, read one entry registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/dsf_scan.sv
module dsf_scan
  import dsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  dsf_req_if.sink   req_ch,
  input  logic      res_ready,
  output result_t   res
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t             state;
  logic [IdW-1:0]     id_q;
  logic [SeqW-1:0]    seq_q;
  logic [CntW-1:0]    issue_cnt;
  logic               chk_vld;
  logic [AddrW-1:0]   chk_addr;
  logic [AddrW-1:0]   ptr;
  logic [TableEntries-1:0] entry_vld;
  logic               fwd_q;
  outcome_t           outc_q;

  logic [AddrW-1:0]   raddr;
  logic [EntryW-1:0]  rdata;
  logic               we;
  logic [AddrW-1:0]   waddr;
  logic               hit;
  logic               seq_same;
  logic               last_chk;
  logic               issue_more;
  logic               accept;

  localparam logic [CntW-1:0] EntriesC = CntW'(TableEntries);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(TableEntries - 1);

  assign req_ch.ready = (state == ST_IDLE);
  assign accept = req_ch.valid && req_ch.ready;

  // Compare the entry read in the previous cycle
  assign raddr = issue_cnt[AddrW-1:0];
  assign issue_more = (issue_cnt < EntriesC);
  assign hit = chk_vld && entry_vld[chk_addr] && (rdata[EntryW-1:SeqW] == id_q);
  assign seq_same = (rdata[SeqW-1:0] == seq_q);
  assign last_chk = chk_vld && (chk_addr == LastAddr);

  // Write back a new sequence on hit, or insert at the pointer on a full miss
  always_comb begin
    we = 1'b0;
    waddr = ptr;
    if (state == ST_SCAN) begin
      if (hit) begin
        we = !seq_same;
        waddr = chk_addr;
      end else if (last_chk) begin
        we = 1'b1;
        waddr = ptr;
      end
    end
  end

  dsf_ram #(
    .Width(EntryW),
    .Depth(TableEntries)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({id_q, seq_q}),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Sequence one request: capture, scan the table, hold the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      issue_cnt <= '0;
      chk_vld <= 1'b0;
      ptr <= '0;
      entry_vld <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            id_q <= req_ch.sender_id;
            seq_q <= req_ch.sequence_req;
            issue_cnt <= '0;
            chk_vld <= 1'b0;
            if (req_ch.sender_id == '0) begin
              fwd_q <= 1'b1;
              outc_q <= OUT_PUBLIC;
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          chk_vld <= issue_more;
          chk_addr <= raddr;
          if (issue_more) begin
            issue_cnt <= issue_cnt + CntW'(1);
          end
          if (hit) begin
            fwd_q <= !seq_same;
            outc_q <= seq_same ? OUT_DUPLICATE : OUT_NEW_SEQ;
            state <= ST_DONE;
          end else if (last_chk) begin
            entry_vld[ptr] <= 1'b1;
            ptr <= (ptr == LastAddr) ? '0 : ptr + AddrW'(1);
            fwd_q <= 1'b1;
            outc_q <= OUT_INSERTED;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign res.valid = (state == ST_DONE);
  assign res.forward = fwd_q;
  assign res.outcome = outc_q;

endmodule
